// ===== rtl/abrm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// abrm_pkg
// Shared types, opcode characters and sizing for the ASCII bytecode machine.
// ----------------------------------------------------------------------------
package abrm_pkg;

   localparam int MEM_BYTES    = 4096;
   localparam int NUM_REGS     = 8;
   localparam int OUT_REGS     = 8;
   localparam int DATA_W       = 32;
   localparam int BYTE_W       = 8;
   localparam int BYTE_COUNT_W = 13;
   localparam int PC_W         = $clog2(MEM_BYTES + 1);
   localparam int REG_IDX_W    = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

   localparam logic [DATA_W-1:0] HASH_MUL = 32'd2654435761;

   // opcode and operand characters
   localparam logic [BYTE_W-1:0] CH_NOP  = 8'h4E; // 'N'
   localparam logic [BYTE_W-1:0] CH_HALT = 8'h48; // 'H'
   localparam logic [BYTE_W-1:0] CH_MOVE = 8'h4D; // 'M'
   localparam logic [BYTE_W-1:0] CH_ADD  = 8'h41; // 'A'
   localparam logic [BYTE_W-1:0] CH_HASH = 8'h23; // '#'
   localparam logic [BYTE_W-1:0] CH_ZERO = 8'h30; // '0'

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_BYTE  = 1'b1;

   typedef enum logic [1:0] {
      ST_READY   = 2'd0,
      ST_RUNNING = 2'd1,
      ST_HALTED  = 2'd2,
      ST_ERROR   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      PH_OPCODE = 2'd0,
      PH_OPND1  = 2'd1,
      PH_OPND2  = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      OP_MOVE = 2'd0,
      OP_ADD  = 2'd1,
      OP_HASH = 2'd2
   } op_type;

   // register file command from the decoder
   typedef struct packed {
      logic                 clear;
      logic                 we;
      op_type               op;
      logic [REG_IDX_W-1:0] dst;
      logic [REG_IDX_W-1:0] src;
      logic [PC_W-1:0]      pc;
   } wr_type;

   function automatic logic digit_ok(input logic [BYTE_W-1:0] ch);
      logic [BYTE_W-1:0] d;
      d = ch - CH_ZERO;
      return (ch >= CH_ZERO) && (d < BYTE_W'(NUM_REGS));
   endfunction

   function automatic logic [REG_IDX_W-1:0] digit_idx(input logic [BYTE_W-1:0] ch);
      logic [BYTE_W-1:0] d;
      d = ch - CH_ZERO;
      return d[REG_IDX_W-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== rtl/ascii_bytecode_register_machine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ascii_bytecode_register_machine
// Runs a jump-free ASCII bytecode, one program byte per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one transfer per program byte (req_command = 1) or a start
//   command (req_command = 0) that clears registers, counter and status.
//   rsp_ channel: exactly one transfer per request, carrying the machine
//   status, byte count and all eight registers as they stand after it.
//   A request in the input register executes once the response slot is free,
//   loading its response. Throughput: one transfer per cycle unless stalled.
//   The request is held in an input register; the architectural state
//   (registers, counter, status) is itself the response register, since it
//   only changes when a new response is loaded.
//   A stalled response holds; the next request is then still taken into the
//   input register, and req_stall rises only once that register is full.
//   Reset: synchronous, active high; both channels empty, machine ready,
//   registers zero. Execution per byte is at most one 32x32 multiply or one add.
// ----------------------------------------------------------------------------
module ascii_bytecode_register_machine (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_command,
   input  wire logic [7:0]  req_program_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_run_status,
   output logic [12:0]      rsp_byte_count,
   output logic [31:0]      rsp_reg_zero,
   output logic [31:0]      rsp_reg_one,
   output logic [31:0]      rsp_reg_two,
   output logic [31:0]      rsp_reg_three,
   output logic [31:0]      rsp_reg_four,
   output logic [31:0]      rsp_reg_five,
   output logic [31:0]      rsp_reg_six,
   output logic [31:0]      rsp_reg_seven
);

   // input register
   logic                          in_valid_ff, in_valid_in;
   logic                          in_cmd_ff;
   logic [abrm_pkg::BYTE_W-1:0]   in_byte_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          fire;

   abrm_pkg::status_type          status;
   logic [abrm_pkg::PC_W-1:0]     pc;
   abrm_pkg::wr_type              wr;
   logic [abrm_pkg::DATA_W-1:0]   reg_out [abrm_pkg::OUT_REGS];

   // execute when the response slot is free or being emptied this cycle
   assign fire         = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall    = in_valid_ff && !fire;
   assign in_valid_in  = req_stall ? 1'b1 : req_valid;
   assign rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload loads whenever the input register can take a transfer
   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_cmd_ff  <= req_command;
         in_byte_ff <= req_program_byte;
      end
   end

   abrm_decode u_decode (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .cmd    (in_cmd_ff),
      .pbyte  (in_byte_ff),
      .status (status),
      .pc     (pc),
      .wr     (wr)
   );

   abrm_regfile u_regfile (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .reg_out (reg_out)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_run_status = status;
   assign rsp_byte_count = abrm_pkg::BYTE_COUNT_W'(pc);
   assign rsp_reg_zero   = reg_out[0];
   assign rsp_reg_one    = reg_out[1];
   assign rsp_reg_two    = reg_out[2];
   assign rsp_reg_three  = reg_out[3];
   assign rsp_reg_four   = reg_out[4];
   assign rsp_reg_five   = reg_out[5];
   assign rsp_reg_six    = reg_out[6];
   assign rsp_reg_seven  = reg_out[7];

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------

   // a start command leaves the machine cleared
   a_start_clears : assert property (@(posedge clock) disable iff (reset)
      fire && (in_cmd_ff == abrm_pkg::CMD_START) |=>
         (rsp_run_status == abrm_pkg::ST_READY) && (rsp_byte_count == '0) &&
         (rsp_reg_zero == '0) && (rsp_reg_seven == '0))
      else $error("start command did not clear the machine");

   // halted or failed machine ignores program bytes
   a_stopped_frozen : assert property (@(posedge clock) disable iff (reset)
      fire && (in_cmd_ff == abrm_pkg::CMD_BYTE) &&
      ((rsp_run_status == abrm_pkg::ST_HALTED) || (rsp_run_status == abrm_pkg::ST_ERROR)) |=>
         $stable(rsp_run_status) && $stable(rsp_byte_count) &&
         $stable(rsp_reg_zero) && $stable(rsp_reg_one))
      else $error("stopped machine changed state");

   // a ready machine has consumed nothing
   a_ready_no_count : assert property (@(posedge clock)
      (rsp_run_status == abrm_pkg::ST_READY) |-> (rsp_byte_count == '0))
      else $error("ready machine with nonzero byte count");

   // state moves only with a new response
   a_state_with_rsp : assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(rsp_byte_count) && $stable(rsp_run_status) && $stable(rsp_reg_two))
      else $error("state changed without a response");

endmodule
`default_nettype wire

// ===== rtl/abrm_decode.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// abrm_decode
// Byte decoder: status, program counter, decode phase and pending operation.
// ----------------------------------------------------------------------------
module abrm_decode (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          fire,
   input  wire logic                          cmd,
   input  wire logic [abrm_pkg::BYTE_W-1:0]   pbyte,
   output abrm_pkg::status_type               status,
   output logic      [abrm_pkg::PC_W-1:0]     pc,
   output abrm_pkg::wr_type                   wr
);

   abrm_pkg::status_type              status_ff, status_in;
   abrm_pkg::phase_type               phase_ff, phase_in;
   abrm_pkg::op_type                  pending_ff, pending_in;
   logic [abrm_pkg::BYTE_W-1:0]       dest_ff, dest_in;
   logic [abrm_pkg::PC_W-1:0]         pc_ff, pc_in;

   logic [abrm_pkg::PC_W-1:0] pc_inc;
   logic                      active;
   logic                      at_end;
   logic                      byte_ok;
   logic                      dest_ok;

   assign pc_inc  = pc_ff + abrm_pkg::PC_W'(1);
   assign active  = (status_ff != abrm_pkg::ST_HALTED) && (status_ff != abrm_pkg::ST_ERROR);
   assign at_end  = (pc_ff >= abrm_pkg::PC_W'(abrm_pkg::MEM_BYTES));
   assign byte_ok = abrm_pkg::digit_ok(pbyte);
   assign dest_ok = abrm_pkg::digit_ok(dest_ff);

   // next state
   always_comb begin
      status_in  = status_ff;
      phase_in   = phase_ff;
      pending_in = pending_ff;
      dest_in    = dest_ff;
      pc_in      = pc_ff;
      if (fire) begin
         if (cmd == abrm_pkg::CMD_START) begin
            status_in  = abrm_pkg::ST_READY;
            phase_in   = abrm_pkg::PH_OPCODE;
            pending_in = abrm_pkg::OP_MOVE;
            dest_in    = '0;
            pc_in      = '0;
         end else if (active) begin
            status_in = abrm_pkg::ST_RUNNING;
            if (at_end) begin
               status_in = (phase_ff == abrm_pkg::PH_OPCODE) ? abrm_pkg::ST_HALTED
                                                             : abrm_pkg::ST_ERROR;
            end else begin
               pc_in = pc_inc;
               case (phase_ff)
                  abrm_pkg::PH_OPCODE: begin
                     case (pbyte)
                        abrm_pkg::CH_NOP: ;
                        abrm_pkg::CH_HALT: status_in = abrm_pkg::ST_HALTED;
                        abrm_pkg::CH_MOVE: begin
                           pending_in = abrm_pkg::OP_MOVE;
                           phase_in   = abrm_pkg::PH_OPND1;
                        end
                        abrm_pkg::CH_ADD: begin
                           pending_in = abrm_pkg::OP_ADD;
                           phase_in   = abrm_pkg::PH_OPND1;
                        end
                        abrm_pkg::CH_HASH: begin
                           pending_in = abrm_pkg::OP_HASH;
                           phase_in   = abrm_pkg::PH_OPND1;
                        end
                        default: status_in = abrm_pkg::ST_ERROR;
                     endcase
                  end
                  abrm_pkg::PH_OPND1: begin
                     if (pending_ff == abrm_pkg::OP_HASH) begin
                        phase_in = abrm_pkg::PH_OPCODE;
                        if (!byte_ok) status_in = abrm_pkg::ST_ERROR;
                     end else begin
                        dest_in  = pbyte;
                        phase_in = abrm_pkg::PH_OPND2;
                     end
                  end
                  abrm_pkg::PH_OPND2: begin
                     phase_in = abrm_pkg::PH_OPCODE;
                     if (!dest_ok || !byte_ok) status_in = abrm_pkg::ST_ERROR;
                  end
                  default: phase_in = abrm_pkg::PH_OPCODE;
               endcase
               // running off the end of program memory
               if ((pc_in >= abrm_pkg::PC_W'(abrm_pkg::MEM_BYTES)) &&
                   (status_in == abrm_pkg::ST_RUNNING)) begin
                  status_in = (phase_in == abrm_pkg::PH_OPCODE) ? abrm_pkg::ST_HALTED
                                                                : abrm_pkg::ST_ERROR;
               end
            end
         end
      end
   end

   // register file command
   always_comb begin
      logic consume;
      consume  = fire && (cmd == abrm_pkg::CMD_BYTE) && active && !at_end;
      wr.clear = fire && (cmd == abrm_pkg::CMD_START);
      wr.op    = pending_ff;
      wr.src   = abrm_pkg::digit_idx(pbyte);
      wr.pc    = pc_inc;
      if (phase_ff == abrm_pkg::PH_OPND1) begin
         wr.dst = abrm_pkg::digit_idx(pbyte);
         wr.we  = consume && (pending_ff == abrm_pkg::OP_HASH) && byte_ok;
      end else begin
         wr.dst = abrm_pkg::digit_idx(dest_ff);
         wr.we  = consume && (phase_ff == abrm_pkg::PH_OPND2) && dest_ok && byte_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff  <= abrm_pkg::ST_READY;
         phase_ff   <= abrm_pkg::PH_OPCODE;
         pending_ff <= abrm_pkg::OP_MOVE;
         dest_ff    <= '0;
         pc_ff      <= '0;
      end else begin
         status_ff  <= status_in;
         phase_ff   <= phase_in;
         pending_ff <= pending_in;
         dest_ff    <= dest_in;
         pc_ff      <= pc_in;
      end
   end

   assign status = status_ff;
   assign pc     = pc_ff;

endmodule
`default_nettype wire

// ===== rtl/abrm_regfile.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// abrm_regfile
// Eight 32-bit registers with move, wrapping add and multiplicative hash.
// ----------------------------------------------------------------------------
module abrm_regfile (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire abrm_pkg::wr_type            wr,
   output logic [abrm_pkg::DATA_W-1:0]      reg_out [abrm_pkg::OUT_REGS]
);

   logic [abrm_pkg::DATA_W-1:0] regs_ff [abrm_pkg::NUM_REGS];
   logic [abrm_pkg::DATA_W-1:0] rd_dst;
   logic [abrm_pkg::DATA_W-1:0] rd_src;
   logic [abrm_pkg::DATA_W-1:0] wdata_in;

   assign rd_dst = regs_ff[wr.dst];
   assign rd_src = regs_ff[wr.src];

   always_comb begin
      case (wr.op)
         abrm_pkg::OP_MOVE: wdata_in = rd_src;
         abrm_pkg::OP_ADD:  wdata_in = rd_dst + rd_src;
         abrm_pkg::OP_HASH: wdata_in = abrm_pkg::DATA_W'(rd_dst * abrm_pkg::HASH_MUL)
                                       ^ abrm_pkg::DATA_W'(wr.pc);
         default:           wdata_in = rd_src;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset || wr.clear) begin
         for (int i = 0; i < abrm_pkg::NUM_REGS; i++) begin
            regs_ff[i] <= '0;
         end
      end else if (wr.we) begin
         regs_ff[wr.dst] <= wdata_in;
      end
   end

   // registers beyond NUM_REGS read as zero
   for (genvar j = 0; j < abrm_pkg::OUT_REGS; j++) begin : g_out
      if (j < abrm_pkg::NUM_REGS) begin : g_live
         assign reg_out[j] = regs_ff[j];
      end else begin : g_none
         assign reg_out[j] = '0;
      end
   end

endmodule
`default_nettype wire

// ===== tb/ascii_bytecode_register_machine_tb.sv =====
// ----------------------------------------------------------------------------
// ascii_bytecode_register_machine_tb
// Self-checking bench: feeds byte programs, compares every status snapshot.
// ----------------------------------------------------------------------------
// A queue of start commands and program bytes drives the request channel. A
// shadow copy of the machine runs each byte as it is taken and queues the
// snapshot the block must return. Short programs are well-formed with random
// content, some broken or noisy. Both channels pause in random bursts, except
// in the closing stretch.
// ----------------------------------------------------------------------------
module ascii_bytecode_register_machine_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import abrm_pkg::*;

   // no transfer on either channel for this many cycles means the block hung
   localparam int HANG_LIMIT   = 500;
   // margin to catch stray transfers at the end
   localparam int DRAIN_CYCLES = 20;
   localparam int SHORT_ITEMS  = 400;

   typedef struct packed {
      logic       command;
      logic [7:0] value;
   } bytecode_item_type;

   // machine state as the block reports it after one transfer
   typedef struct packed {
      logic [1:0]       status;
      logic [12:0]      count;
      logic [7:0][31:0] regs;
   } machine_view_type;

   logic clock;
   logic reset = 1'b1;

   logic        req_valid        = 1'b0;
   logic        req_stall;
   logic        req_command      = CMD_BYTE;
   logic [7:0]  req_program_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall        = 1'b0;
   logic [1:0]  rsp_run_status;
   logic [12:0] rsp_byte_count;
   logic [31:0] rsp_reg_zero, rsp_reg_one, rsp_reg_two, rsp_reg_three;
   logic [31:0] rsp_reg_four, rsp_reg_five, rsp_reg_six, rsp_reg_seven;

   wire [7:0][31:0] rsp_regs = {rsp_reg_seven, rsp_reg_six, rsp_reg_five, rsp_reg_four,
                                rsp_reg_three, rsp_reg_two, rsp_reg_one, rsp_reg_zero};

   ascii_bytecode_register_machine dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_program_byte (req_program_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_run_status   (rsp_run_status),
      .rsp_byte_count   (rsp_byte_count),
      .rsp_reg_zero     (rsp_reg_zero),
      .rsp_reg_one      (rsp_reg_one),
      .rsp_reg_two      (rsp_reg_two),
      .rsp_reg_three    (rsp_reg_three),
      .rsp_reg_four     (rsp_reg_four),
      .rsp_reg_five     (rsp_reg_five),
      .rsp_reg_six      (rsp_reg_six),
      .rsp_reg_seven    (rsp_reg_seven)
   );

   bytecode_item_type bytecode_q[$];        // stimulus not yet offered
   machine_view_type  machine_state_q[$];   // snapshots still owed by the block
   bytecode_item_type next_item;
   machine_view_type  owed_state;
   int                mismatches   = 0;
   int                cycle_count  = 0;
   int                prog_len     = 0;     // bytes since the last start command
   int                gap_left     = 0;
   int                stall_left   = 0;

   // shadow machine
   logic [7:0][31:0] shadow_regs;
   logic [12:0]      shadow_pc;
   status_type       shadow_status;
   phase_type        shadow_phase;
   op_type           shadow_op;
   logic [7:0]       shadow_dest;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Shadow machine
   // ---------------------------------------------------------------------
   function automatic bit is_reg_digit(input logic [7:0] ch);
      return ch >= CH_ZERO && ch < CH_ZERO + NUM_REGS;
   endfunction

   // start command and reset leave the machine in the same state
   task automatic clear_machine();
      shadow_regs   = '0;
      shadow_pc     = '0;
      shadow_status = ST_READY;
      shadow_phase  = PH_OPCODE;
      shadow_op     = OP_MOVE;
      shadow_dest   = '0;
   endtask

   task automatic execute_item(input logic command, input logic [7:0] value);
      machine_view_type snap;
      int d;
      int s;
      if (command == CMD_START) begin
         clear_machine();
      end else if (shadow_status != ST_HALTED && shadow_status != ST_ERROR) begin
         // halted and error swallow bytes; otherwise the machine is running
         shadow_status = ST_RUNNING;
         shadow_pc++;
         case (shadow_phase)
            PH_OPCODE: begin
               case (value)
                  CH_NOP: begin
                  end
                  CH_HALT: shadow_status = ST_HALTED;
                  CH_MOVE: begin
                     shadow_op    = OP_MOVE;
                     shadow_phase = PH_OPND1;
                  end
                  CH_ADD: begin
                     shadow_op    = OP_ADD;
                     shadow_phase = PH_OPND1;
                  end
                  CH_HASH: begin
                     shadow_op    = OP_HASH;
                     shadow_phase = PH_OPND1;
                  end
                  default: shadow_status = ST_ERROR;
               endcase
            end
            PH_OPND1: begin
               if (shadow_op == OP_HASH) begin
                  // hash mixes in the count after its operand byte
                  shadow_phase = PH_OPCODE;
                  if (!is_reg_digit(value)) begin
                     shadow_status = ST_ERROR;
                  end else begin
                     d = value - CH_ZERO;
                     shadow_regs[d] = (shadow_regs[d] * HASH_MUL) ^ 32'(shadow_pc);
                  end
               end else begin
                  shadow_dest  = value;
                  shadow_phase = PH_OPND2;
               end
            end
            default: begin
               // both operands are only judged once the second one is in
               shadow_phase = PH_OPCODE;
               if (!is_reg_digit(shadow_dest) || !is_reg_digit(value)) begin
                  shadow_status = ST_ERROR;
               end else begin
                  d = shadow_dest - CH_ZERO;
                  s = value - CH_ZERO;
                  if (shadow_op == OP_ADD)
                     shadow_regs[d] = shadow_regs[d] + shadow_regs[s];
                  else
                     shadow_regs[d] = shadow_regs[s];
               end
            end
         endcase
         // end of program memory: clean stop only between instructions
         if (shadow_pc >= MEM_BYTES && shadow_status == ST_RUNNING) begin
            if (shadow_phase == PH_OPCODE)
               shadow_status = ST_HALTED;
            else
               shadow_status = ST_ERROR;
         end
      end
      snap.status = shadow_status;
      snap.count  = shadow_pc;
      snap.regs   = shadow_regs;
      machine_state_q.push_back(snap);
   endtask

   // ---------------------------------------------------------------------
   // Program builders
   // ---------------------------------------------------------------------
   task automatic push_start();
      bytecode_item_type it;
      it.command = CMD_START;
      it.value   = 8'($urandom_range(0, 255));   // payload is don't-care
      bytecode_q.push_back(it);
      prog_len = 0;
   endtask

   task automatic push_byte(input logic [7:0] value);
      bytecode_item_type it;
      it.command = CMD_BYTE;
      it.value   = value;
      bytecode_q.push_back(it);
      prog_len++;
   endtask

   function automatic logic [7:0] good_digit();
      return CH_ZERO + 8'($urandom_range(0, NUM_REGS - 1));
   endfunction

   function automatic logic [7:0] bad_digit();
      logic [7:0] ch;
      if ($urandom_range(0, 1))
         return CH_ZERO + 8'($urandom_range(NUM_REGS, 9));
      do
         ch = 8'($urandom_range(0, 255));
      while (is_reg_digit(ch));
      return ch;
   endfunction

   function automatic logic [7:0] two_operand_op();
      return $urandom_range(0, 1) ? CH_ADD : CH_MOVE;
   endfunction

   // one complete, legal instruction; weighted toward register traffic
   task automatic emit_good();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         push_byte(CH_NOP);
      end else if (pick <= 3) begin
         push_byte(CH_HASH);
         push_byte(good_digit());
      end else begin
         push_byte(two_operand_op());
         push_byte(good_digit());
         push_byte(good_digit());
      end
   endtask

   task automatic emit_bad();
      logic [7:0] junk;
      case ($urandom_range(0, 3))
         0: begin
            do
               junk = 8'($urandom_range(0, 255));
            while (junk == CH_NOP || junk == CH_HALT || junk == CH_MOVE ||
                   junk == CH_ADD || junk == CH_HASH);
            push_byte(junk);
         end
         1: begin
            push_byte(CH_HASH);
            push_byte(bad_digit());
         end
         2: begin
            push_byte(two_operand_op());
            push_byte(bad_digit());
            push_byte(good_digit());
         end
         default: begin
            push_byte(two_operand_op());
            push_byte(good_digit());
            push_byte(bad_digit());
         end
      endcase
   endtask

   // short programs until about `goal` non-ignored items were queued
   task automatic short_programs(input int goal);
      int tally;
      int kind;
      tally = 0;
      while (tally < goal) begin
         push_start();
         kind = $urandom_range(0, 9);
         repeat ($urandom_range(2, 25)) emit_good();
         if (kind < 4) begin
            push_byte(CH_HALT);
         end else if (kind < 7) begin
            // left open, sometimes mid-instruction, for the next start to cut
            if ($urandom_range(0, 1)) begin
               push_byte(two_operand_op());
               push_byte(good_digit());
            end
         end else if (kind < 9) begin
            emit_bad();
         end else begin
            repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)));
         end
         tally += prog_len + 1;
         // bytes after halt or error are swallowed
         if (kind < 4 || kind >= 7)
            repeat ($urandom_range(0, 2)) push_byte(8'($urandom_range(0, 255)));
      end
   endtask

   // idle and stall bursts: off one window in four, and off near the end
   function automatic bit bursts_allowed();
      return (cycle_count % 1024) < 768 && bytecode_q.size() > 150;
   endfunction

   // ---------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------
   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: %s mismatch: expected %h, got %h", $realtime, name, want, got);
      end
   endtask

   always @(posedge clock)
      cycle_count <= cycle_count + 1;

   // request driver: predicts each transfer as it is taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
         clear_machine();
      end else begin
         if (req_valid && !req_stall)
            execute_item(req_command, req_program_byte);
         // a stalled request holds; otherwise pick idle or the next item
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (bytecode_q.size() != 0 && bursts_allowed() &&
                         $urandom_range(0, 5) == 0) begin
               gap_left = $urandom_range(0, 11);
               req_valid <= 1'b0;
            end else if (bytecode_q.size() != 0) begin
               next_item = bytecode_q.pop_front();
               req_valid        <= 1'b1;
               req_command      <= next_item.command;
               req_program_byte <= next_item.value;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (bursts_allowed() && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 11);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // response monitor: oldest owed snapshot against each transfer
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (machine_state_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: response transfer with nothing owed", $realtime);
         end else begin
            owed_state = machine_state_q.pop_front();
            check_field("run_status", 32'(rsp_run_status), 32'(owed_state.status));
            check_field("byte_count", 32'(rsp_byte_count), 32'(owed_state.count));
            for (int i = 0; i < OUT_REGS; i++)
               check_field($sformatf("reg %0d", i), rsp_regs[i], owed_state.regs[i]);
         end
      end
   end

   // hang detector
   initial begin : hang_watch
      int quiet;
      quiet = 0;
      while (quiet < HANG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
      end
      $display("Verification failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Stimulus and end of run
   // ---------------------------------------------------------------------
   initial begin
      // directed: first byte straight out of reset, then every opcode
      push_byte(CH_NOP);
      push_byte(CH_HASH);  push_byte(CH_ZERO + 8'd3);
      push_byte(CH_HASH);  push_byte(CH_ZERO + 8'd7);
      push_byte(CH_MOVE);  push_byte(CH_ZERO);  push_byte(CH_ZERO + 8'd3);
      push_byte(CH_ADD);   push_byte(CH_ZERO);  push_byte(CH_ZERO + 8'd7);
      push_byte(CH_ADD);   push_byte(CH_ZERO);  push_byte(CH_ZERO);
      push_byte(CH_HALT);
      push_byte(CH_NOP);                       // swallowed while halted
      push_start();
      push_byte(8'h00);                        // zero byte is an unknown opcode
      push_byte(8'hFF);                        // swallowed while in error
      push_start();
      push_byte(CH_HASH);  push_byte(CH_ZERO + 8'd8);
      push_start();
      push_byte(CH_MOVE);  push_byte(CH_ZERO + 8'd9);  push_byte(CH_ZERO + 8'd1);
      push_start();
      push_byte(CH_ADD);   push_byte(CH_ZERO + 8'd2);  push_byte(CH_ZERO - 8'd1);

      short_programs(SHORT_ITEMS / 2);
      short_programs(SHORT_ITEMS / 2);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (bytecode_q.size() != 0 || req_valid) @(posedge clock);
      while (machine_state_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && machine_state_q.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
